/* sv/page_frame_buffer_glyph_writer_defines.svh */
`ifndef PAGE_FRAME_BUFFER_GLYPH_WRITER_DEFINES_SVH
`define PAGE_FRAME_BUFFER_GLYPH_WRITER_DEFINES_SVH

// same-cycle implication, clocked on clk, off while in reset
`define PFBGW_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off while in reset
`define PFBGW_ASSERT_NXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* sv/pfbgw_pkg.sv */
`default_nettype none

package pfbgw_pkg;

    localparam int COLUMNS      = 128;
    localparam int PAGES        = 8;
    localparam int GLYPH_HEIGHT = 32;

    localparam int ROWS          = PAGES * 8;
    localparam int BYTES_PER_COL = GLYPH_HEIGHT / 8;
    localparam int GCOL_SHIFT    = $clog2(BYTES_PER_COL);
    localparam int COL_AW        = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int PAGE_W        = (PAGES > 1) ? $clog2(PAGES) : 1;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_GLYPH = 2'd1,
        KIND_READ  = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    // what every lane sees of an accepted transaction
    typedef struct packed {
        logic [COL_AW-1:0] col;
        logic [8:0]        start;
        logic              glyph;
        logic              pixel_on;
        logic [7:0]        glyph_byte;
    } lane_cmd_t;

    typedef struct packed {
        logic              req;
        logic              ok;
        logic [PAGE_W-1:0] page;
    } read_sel_t;

    typedef logic [PAGES-1:0][7:0] lane_bytes_t;

endpackage

`default_nettype wire

/* sv/page_frame_buffer_glyph_writer.sv */
`default_nettype none

// Every command is taken at an edge where start is high and busy is low; busy is
// then high for exactly one cycle while all page lanes finish their read-modify-write
// of one column, and no new command is taken while busy is high.
// A read answers with result_strobe and column_byte for one cycle, in the cycle after
// the busy cycle; the receiver cannot stall it, so it must take the byte in that
// cycle. Reads off the screen still answer, with zero. The store is clear right after
// reset and a clear-all command also finishes within its busy cycle: a per-column
// valid bit marks columns written since, so there is no clearing pass.

`include "page_frame_buffer_glyph_writer_defines.svh"

module page_frame_buffer_glyph_writer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] kind,
    input  wire logic [7:0] x,
    input  wire logic [6:0] y,
    input  wire logic       pixel_on,
    input  wire logic [6:0] byte_index,
    input  wire logic [7:0] glyph_byte,
    output logic            result_strobe,
    output logic [7:0]      column_byte
);

    pfbgw_pkg::state_t            state_reg;
    pfbgw_pkg::state_t            state_next;
    pfbgw_pkg::kind_t             op_reg;
    pfbgw_pkg::kind_t             kind_in;
    logic                         accept;
    logic [8:0]                   glyph_col;
    logic [8:0]                   glyph_start;
    logic [8:0]                   col_full;
    logic                         col_ok;
    logic                         col_ok_reg;
    logic [pfbgw_pkg::COL_AW-1:0] col_reg;
    logic                         rd_ok;
    logic                         rd_ok_reg;
    logic [pfbgw_pkg::PAGE_W-1:0] rd_page_reg;
    logic [pfbgw_pkg::COLUMNS-1:0] valid_reg;
    logic [pfbgw_pkg::COLUMNS-1:0] valid_next;
    logic                         row_valid;
    logic                         commit;
    pfbgw_pkg::lane_cmd_t         cmd;
    pfbgw_pkg::lane_bytes_t       lane_bytes;
    pfbgw_pkg::read_sel_t         sel;

    assign kind_in = pfbgw_pkg::kind_t'(kind);
    assign busy    = (state_reg == pfbgw_pkg::ST_EXEC);
    assign accept  = start && !busy;

    // glyph byte placement
    assign glyph_col   = {1'b0, x} + 9'(byte_index >> pfbgw_pkg::GCOL_SHIFT);
    assign glyph_start = {2'b00, y}
                         + 9'(7'(byte_index & 7'(pfbgw_pkg::BYTES_PER_COL - 1)) << 3);

    assign col_full = (kind_in == pfbgw_pkg::KIND_GLYPH) ? glyph_col : {1'b0, x};
    assign col_ok   = (col_full < 9'(pfbgw_pkg::COLUMNS));
    assign rd_ok    = ({1'b0, x} < 9'(pfbgw_pkg::COLUMNS))
                      && ({1'b0, y[6:3]} < 5'(pfbgw_pkg::PAGES));

    always_comb
    begin
        cmd.col        = col_full[pfbgw_pkg::COL_AW-1:0];
        cmd.start      = (kind_in == pfbgw_pkg::KIND_GLYPH) ? glyph_start : {2'b00, y};
        cmd.glyph      = (kind_in == pfbgw_pkg::KIND_GLYPH);
        cmd.pixel_on   = pixel_on;
        cmd.glyph_byte = glyph_byte;
    end

    assign row_valid = valid_reg[col_reg];
    assign commit    = busy && col_ok_reg
                       && ((op_reg == pfbgw_pkg::KIND_PIXEL) || (op_reg == pfbgw_pkg::KIND_GLYPH));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfbgw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = pfbgw_pkg::ST_EXEC;
                end
            end
            pfbgw_pkg::ST_EXEC:
            begin
                state_next = pfbgw_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pfbgw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (busy && (op_reg == pfbgw_pkg::KIND_CLEAR))
        begin
            valid_next = '0;
        end
        else if (commit)
        begin
            valid_next[col_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfbgw_pkg::ST_IDLE;
            op_reg    <= pfbgw_pkg::KIND_PIXEL;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            if (accept)
            begin
                op_reg <= kind_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_ok_reg  <= col_ok;
            col_reg     <= cmd.col;
            rd_ok_reg   <= rd_ok;
            rd_page_reg <= y[3 +: pfbgw_pkg::PAGE_W];
        end
    end

    // one lane per page
    for (genvar p = 0; p < pfbgw_pkg::PAGES; p++) begin : g_lane
        pfbgw_lane u_lane (
            .clk       (clk),
            .page      (pfbgw_pkg::PAGE_W'(p)),
            .load      (accept),
            .cmd       (cmd),
            .commit    (commit),
            .row_valid (row_valid),
            .old_byte  (lane_bytes[p])
        );
    end

    always_comb
    begin
        sel.req  = busy && (op_reg == pfbgw_pkg::KIND_READ);
        sel.ok   = rd_ok_reg;
        sel.page = rd_page_reg;
    end

    pfbgw_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .lane_bytes    (lane_bytes),
        .sel           (sel),
        .result_strobe (result_strobe),
        .column_byte   (column_byte)
    );

    `PFBGW_ASSERT_NXT(a_accept_busy, accept, busy, "accepted transaction did not raise busy")
    `PFBGW_ASSERT_NXT(a_busy_one, busy, !busy, "busy held longer than one cycle")
    `PFBGW_ASSERT_IMP(a_strobe_src, result_strobe,
        $past(busy && (op_reg == pfbgw_pkg::KIND_READ)), "result without a read")
    `PFBGW_ASSERT_NXT(a_clear_all, busy && (op_reg == pfbgw_pkg::KIND_CLEAR),
        valid_reg == '0, "clear left a column marked written")

endmodule

`default_nettype wire

/* sv/pfbgw_lane.sv */
`default_nettype none

module pfbgw_lane (
    input  wire logic                        clk,
    input  wire logic [pfbgw_pkg::PAGE_W-1:0] page,
    input  wire logic                        load,
    input  wire pfbgw_pkg::lane_cmd_t        cmd,
    input  wire logic                        commit,
    input  wire logic                        row_valid,
    output logic [7:0]                       old_byte
);

    logic [7:0]                   mem [pfbgw_pkg::COLUMNS];
    logic [7:0]                   rd_reg;
    logic [7:0]                   mask_reg;
    logic [7:0]                   mask_next;
    logic [7:0]                   bits_reg;
    logic [7:0]                   bits_next;
    logic [pfbgw_pkg::COL_AW-1:0] col_reg;
    logic [7:0]                   new_byte;
    logic                         we;

    // per-bit mask and value for this page
    for (genvar b = 0; b < 8; b++) begin : g_bit
        logic [8:0] row_abs;
        logic [8:0] diff;
        logic       in_span;
        logic [2:0] k;

        assign row_abs = 9'({page, 3'(b)});
        assign diff    = row_abs - cmd.start;
        assign k       = diff[2:0];
        assign in_span = (row_abs >= cmd.start)
                         && (cmd.glyph ? (diff < 9'd8) : (diff == 9'd0));
        assign mask_next[b] = in_span;
        assign bits_next[b] = cmd.glyph ? cmd.glyph_byte[3'd7 - k] : cmd.pixel_on;
    end

    assign old_byte = row_valid ? rd_reg : 8'd0;
    assign new_byte = (old_byte & ~mask_reg) | (bits_reg & mask_reg);
    assign we       = commit && ((mask_reg != 8'd0) || !row_valid);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rd_reg   <= mem[cmd.col];
            mask_reg <= mask_next;
            bits_reg <= bits_next;
            col_reg  <= cmd.col;
        end
        if (we)
        begin
            mem[col_reg] <= new_byte;
        end
    end

endmodule

`default_nettype wire

/* sv/pfbgw_merge.sv */
`default_nettype none

module pfbgw_merge (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire pfbgw_pkg::lane_bytes_t lane_bytes,
    input  wire pfbgw_pkg::read_sel_t   sel,
    output logic                        result_strobe,
    output logic [7:0]                  column_byte
);

    logic       strobe_reg;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    assign byte_next = sel.ok ? lane_bytes[sel.page] : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= sel.req;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel.req)
        begin
            byte_reg <= byte_next;
        end
    end

    assign result_strobe = strobe_reg;
    assign column_byte   = byte_reg;

endmodule

`default_nettype wire

/* sim/page_frame_buffer_glyph_writer_test.sv */
`timescale 1ns / 1ps

module page_frame_buffer_glyph_writer_test;

    class frame_shadow;
        logic [7:0] shadow_store [pfbgw_pkg::COLUMNS*pfbgw_pkg::PAGES];
        logic [7:0] pending_bytes [$];
        int errors;

        function new();
            foreach (shadow_store[i])
            begin
                shadow_store[i] = '0;
            end
            errors = 0;
        endfunction

        function void put_pixel(int col, int row, bit on);
            int addr;
            if (col >= pfbgw_pkg::COLUMNS || row >= pfbgw_pkg::ROWS)
                return;
            addr = (row / 8) * pfbgw_pkg::COLUMNS + col;
            shadow_store[addr][row % 8] = on;
        endfunction

        function void note_command(pfbgw_pkg::kind_t k, logic [7:0] cx, logic [6:0] cy,
                                   logic on, logic [6:0] idx, logic [7:0] gb);
            int col;
            int row;
            int page;
            case (k)
                pfbgw_pkg::KIND_PIXEL:
                begin
                    put_pixel(int'(cx), int'(cy), on);
                end
                pfbgw_pkg::KIND_GLYPH:
                begin
                    col = int'(cx) + int'(idx) / pfbgw_pkg::BYTES_PER_COL;
                    row = int'(cy) + (int'(idx) % pfbgw_pkg::BYTES_PER_COL) * 8;
                    for (int b = 0; b < 8; b++)
                    begin
                        put_pixel(col, row + b, gb[7 - b]);
                    end
                end
                pfbgw_pkg::KIND_READ:
                begin
                    page = int'(cy) / 8;
                    if (int'(cx) < pfbgw_pkg::COLUMNS && page < pfbgw_pkg::PAGES)
                        pending_bytes.push_back(
                            shadow_store[page * pfbgw_pkg::COLUMNS + int'(cx)]);
                    else
                        pending_bytes.push_back(8'h00);
                end
                default:
                begin
                    foreach (shadow_store[i])
                    begin
                        shadow_store[i] = '0;
                    end
                end
            endcase
        endfunction

        function void check_byte(logic [7:0] actual);
            logic [7:0] wanted;
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected read result, actual %02h", $time, actual);
                errors++;
                return;
            end
            wanted = pending_bytes.pop_front();
            if (actual !== wanted)
            begin
                $display("%0t: column_byte mismatch, expected %02h actual %02h",
                         $time, wanted, actual);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] kind;
    logic [7:0] x;
    logic [6:0] y;
    logic       pixel_on;
    logic [6:0] byte_index;
    logic [7:0] glyph_byte;
    logic       result_strobe;
    logic [7:0] column_byte;

    frame_shadow sb = new();

    page_frame_buffer_glyph_writer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .x             (x),
        .y             (y),
        .pixel_on      (pixel_on),
        .byte_index    (byte_index),
        .glyph_byte    (glyph_byte),
        .result_strobe (result_strobe),
        .column_byte   (column_byte)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
            sb.check_byte(column_byte);
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_cmd(pfbgw_pkg::kind_t k, logic [7:0] cx, logic [6:0] cy, logic on,
                            logic [6:0] idx, logic [7:0] gb);
        @(negedge clk);
        start      <= 1'b1;
        kind       <= k;
        x          <= cx;
        y          <= cy;
        pixel_on   <= on;
        byte_index <= idx;
        glyph_byte <= gb;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(k, cx, cy, on, idx, gb);
    endtask

    // fields carry noise while start is low
    task automatic idle_gap(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start      <= 1'b0;
            kind       <= 2'($urandom);
            x          <= 8'($urandom);
            y          <= 7'($urandom);
            pixel_on   <= 1'($urandom);
            byte_index <= 7'($urandom);
            glyph_byte <= 8'($urandom);
        end
    endtask

    task automatic random_cmd();
        pfbgw_pkg::kind_t k;
        logic [7:0]       cx;
        logic [6:0]       cy;
        logic [6:0]       idx;
        int               r;
        r = $urandom_range(0, 99);
        k = (r < 30) ? pfbgw_pkg::KIND_PIXEL :
            (r < 58) ? pfbgw_pkg::KIND_GLYPH :
            (r < 99) ? pfbgw_pkg::KIND_READ : pfbgw_pkg::KIND_CLEAR;
        r = $urandom_range(0, 9);
        if (r < 5)
        begin
            cx = 8'($urandom_range(0, 15));
            cy = 7'($urandom_range(0, 31));
        end
        else if (r < 8)
        begin
            cx = 8'($urandom_range(0, pfbgw_pkg::COLUMNS - 1));
            cy = 7'($urandom_range(0, pfbgw_pkg::ROWS - 1));
        end
        else
        begin
            cx = 8'($urandom_range(0, 255));
            cy = 7'($urandom_range(0, 127));
        end
        idx = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 15))
                                          : 7'($urandom_range(0, 127));
        send_cmd(k, cx, cy, 1'($urandom_range(0, 1)), idx, 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int idle_pct;
        rst_n      = 1'b0;
        start      = 1'b0;
        kind       = pfbgw_pkg::KIND_PIXEL;
        x          = '0;
        y          = '0;
        pixel_on   = 1'b0;
        byte_index = '0;
        glyph_byte = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // corners, off-screen pixels and reads
        send_cmd(pfbgw_pkg::KIND_PIXEL, 8'd0, 7'd0, 1'b1, 7'd0, 8'h00);
        send_cmd(pfbgw_pkg::KIND_PIXEL, 8'd127, 7'd63, 1'b1, 7'd0, 8'h00);
        send_cmd(pfbgw_pkg::KIND_PIXEL, 8'd128, 7'd5, 1'b1, 7'd0, 8'h00);
        send_cmd(pfbgw_pkg::KIND_PIXEL, 8'd5, 7'd64, 1'b1, 7'd0, 8'h00);
        send_cmd(pfbgw_pkg::KIND_PIXEL, 8'd255, 7'd127, 1'b1, 7'd127, 8'hff);
        send_cmd(pfbgw_pkg::KIND_READ, 8'd0, 7'd0, 1'b0, 7'd0, 8'h00);
        send_cmd(pfbgw_pkg::KIND_READ, 8'd127, 7'd63, 1'b0, 7'd0, 8'h00);
        send_cmd(pfbgw_pkg::KIND_READ, 8'd128, 7'd5, 1'b0, 7'd0, 8'h00);
        send_cmd(pfbgw_pkg::KIND_READ, 8'd5, 7'd64, 1'b0, 7'd0, 8'h00);
        send_cmd(pfbgw_pkg::KIND_PIXEL, 8'd0, 7'd0, 1'b0, 7'd0, 8'h00);
        send_cmd(pfbgw_pkg::KIND_READ, 8'd0, 7'd0, 1'b1, 7'd127, 8'hff);
        // glyph bytes straddling pages, partly and fully off screen
        send_cmd(pfbgw_pkg::KIND_GLYPH, 8'd10, 7'd5, 1'b0, 7'd0, 8'h81);
        send_cmd(pfbgw_pkg::KIND_GLYPH, 8'd10, 7'd5, 1'b0, 7'd5, 8'hff);
        send_cmd(pfbgw_pkg::KIND_READ, 8'd10, 7'd0, 1'b0, 7'd0, 8'h00);
        send_cmd(pfbgw_pkg::KIND_READ, 8'd10, 7'd8, 1'b0, 7'd0, 8'h00);
        send_cmd(pfbgw_pkg::KIND_READ, 8'd11, 7'd8, 1'b0, 7'd0, 8'h00);
        send_cmd(pfbgw_pkg::KIND_READ, 8'd11, 7'd16, 1'b0, 7'd0, 8'h00);
        send_cmd(pfbgw_pkg::KIND_GLYPH, 8'd120, 7'd60, 1'b1, 7'd127, 8'hff);
        send_cmd(pfbgw_pkg::KIND_GLYPH, 8'd127, 7'd60, 1'b0, 7'd0, 8'ha5);
        send_cmd(pfbgw_pkg::KIND_READ, 8'd127, 7'd56, 1'b0, 7'd0, 8'h00);
        send_cmd(pfbgw_pkg::KIND_GLYPH, 8'd255, 7'd127, 1'b1, 7'd127, 8'hff);
        send_cmd(pfbgw_pkg::KIND_GLYPH, 8'd10, 7'd5, 1'b0, 7'd0, 8'h00);
        send_cmd(pfbgw_pkg::KIND_READ, 8'd10, 7'd0, 1'b0, 7'd0, 8'h00);
        send_cmd(pfbgw_pkg::KIND_CLEAR, 8'd255, 7'd127, 1'b1, 7'd127, 8'hff);
        send_cmd(pfbgw_pkg::KIND_READ, 8'd127, 7'd63, 1'b0, 7'd0, 8'h00);

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 17 : (phase == 1) ? 87 : 0;
            repeat (317)
            begin
                while ($urandom_range(0, 99) < idle_pct)
                    idle_gap(1);
                random_cmd();
            end
        end
        idle_gap(1);

        while (sb.pending_bytes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.errors == 0 && sb.pending_bytes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/pfbgw_pkg.sv
sv/pfbgw_lane.sv
sv/pfbgw_merge.sv
sv/page_frame_buffer_glyph_writer.sv
sim/page_frame_buffer_glyph_writer_test.sv
